// File: hw/rtl/rnv_pkg.sv
// shared types, constants and helper functions for the rgb to nv21 converter
package rnv_pkg;

  localparam int PIX_W         = 32;
  localparam int BYTE_W        = 8;
  localparam int CFG_DIM_W     = 13;
  localparam int LUMA_ADDR_W   = 24;
  localparam int CHROMA_ADDR_W = 25;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int DIM_MAX_VAL   = 8191;

  // register indexes, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // bt.601 studio-range coefficients
  localparam logic signed [17:0] C_Y_R = 18'sd66;
  localparam logic signed [17:0] C_Y_G = 18'sd129;
  localparam logic signed [17:0] C_Y_B = 18'sd25;
  localparam logic signed [17:0] C_U_R = -18'sd38;
  localparam logic signed [17:0] C_U_G = -18'sd74;
  localparam logic signed [17:0] C_U_B = 18'sd112;
  localparam logic signed [17:0] C_V_R = 18'sd112;
  localparam logic signed [17:0] C_V_G = -18'sd94;
  localparam logic signed [17:0] C_V_B = -18'sd18;
  localparam logic signed [17:0] ROUND_C      = 18'sd128;
  localparam logic signed [17:0] CHROMA_BIAS  = 18'sd32768;
  localparam logic signed [10:0] LUMA_OFFSET  = 11'sd16;
  localparam logic signed [10:0] LUMA_LO      = 11'sd16;
  localparam logic signed [10:0] CHROMA_LO    = 11'sd0;
  localparam logic signed [10:0] BYTE_HI      = 11'sd255;

  typedef struct packed {
    logic [CFG_DIM_W-1:0]     eff_width;
    logic [CFG_DIM_W-1:0]     eff_height;
    logic [CHROMA_ADDR_W-1:0] frame_size;
    logic                     restart;
  } cfg_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] luma;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] u;
  } yuv_t;

  typedef struct packed {
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic [CHROMA_ADDR_W-1:0] chroma_address;
    logic                     frame_end;
  } pos_t;

  function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [10:0] val,
                                                   input logic signed [10:0] lo);
    logic [BYTE_W-1:0] res;
    if (val < lo) begin
      res = lo[BYTE_W-1:0];
    end else if (val > BYTE_HI) begin
      res = BYTE_HI[BYTE_W-1:0];
    end else begin
      res = val[BYTE_W-1:0];
    end
    return res;
  endfunction

  // zero counts as one, anything above the limit saturates
  function automatic logic [CFG_DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] val,
                                                   input logic [CFG_DIM_W-1:0] maxv);
    logic [CFG_DIM_W-1:0] res;
    if (val == '0) begin
      res = CFG_DIM_W'(1);
    end else if (val > maxv) begin
      res = maxv;
    end else begin
      res = val;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/rnv_cfg_regs.sv
// apb register file for frame size, effective dimensions and frame size product
module rnv_cfg_regs
  import rnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_stat_t             cfg
);

  localparam logic [CFG_DIM_W-1:0] MAXW_C =
      CFG_DIM_W'((MAX_WIDTH > DIM_MAX_VAL) ? DIM_MAX_VAL : MAX_WIDTH);
  localparam logic [CFG_DIM_W-1:0] MAXH_C =
      CFG_DIM_W'((MAX_HEIGHT > DIM_MAX_VAL) ? DIM_MAX_VAL : MAX_HEIGHT);

  logic [CFG_DIM_W-1:0]     width_r, height_r;
  logic [CHROMA_ADDR_W-1:0] frame_size_r;
  logic [CFG_DIM_W-1:0]     eff_w, eff_h;
  logic [2*CFG_DIM_W-1:0]   frame_size_nxt;
  logic                     wr_en;
  logic                     reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w          = eff_dim(width_r, MAXW_C);
  assign eff_h          = eff_dim(height_r, MAXH_C);
  assign frame_size_nxt = eff_w * eff_h;

  // frame size product is registered from the effective width and height
  always_ff @(posedge clk) begin
    frame_size_r <= frame_size_nxt[CHROMA_ADDR_W-1:0];
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.eff_width  = eff_w;
  assign cfg.eff_height = eff_h;
  assign cfg.frame_size = frame_size_r;
  assign cfg.restart    = wr_en;

endmodule

// File: hw/rtl/rnv_color.sv
// bt.601 rgb to yuv arithmetic with clamping
module rnv_color
  import rnv_pkg::*;
(
  input  logic [PIX_W-1:0] pixel_word,
  output yuv_t             yuv
);

  logic signed [17:0] sr, sg, sb;
  logic signed [17:0] ys, us, vs;
  logic signed [10:0] y_full, u_full, v_full;

  assign sr = $signed({10'b0, pixel_word[7:0]});
  assign sg = $signed({10'b0, pixel_word[15:8]});
  assign sb = $signed({10'b0, pixel_word[23:16]});

  // biased sums never go negative, so the shift is a plain floor
  assign ys = C_Y_R * sr + C_Y_G * sg + C_Y_B * sb + ROUND_C;
  assign us = C_U_R * sr + C_U_G * sg + C_U_B * sb + ROUND_C + CHROMA_BIAS;
  assign vs = C_V_R * sr + C_V_G * sg + C_V_B * sb + ROUND_C + CHROMA_BIAS;

  assign y_full = $signed({1'b0, ys[17:8]}) + LUMA_OFFSET;
  assign u_full = $signed({1'b0, us[17:8]});
  assign v_full = $signed({1'b0, vs[17:8]});

  assign yuv.luma = clamp_byte(y_full, LUMA_LO);
  assign yuv.u    = clamp_byte(u_full, CHROMA_LO);
  assign yuv.v    = clamp_byte(v_full, CHROMA_LO);

endmodule

// File: hw/rtl/rnv_pos.sv
// raster position counters and luma / chroma address generation
module rnv_pos
  import rnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_stat_t cfg,
  input  logic      advance,
  output pos_t      pos
);

  localparam int COL_W    = ($clog2(MAX_WIDTH) > CFG_DIM_W) ? CFG_DIM_W : $clog2(MAX_WIDTH);
  localparam int ROW_W    = ($clog2(MAX_HEIGHT) > CFG_DIM_W) ? CFG_DIM_W : $clog2(MAX_HEIGHT);
  localparam int DIM_P1_W = CFG_DIM_W + 1;

  logic [COL_W-1:0]         col_r, col_nxt, col_even;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [LUMA_ADDR_W-1:0]   luma_ptr_r, luma_ptr_nxt;
  logic [CHROMA_ADDR_W-1:0] chroma_off_r, chroma_off_nxt;
  logic                     last_col, last_row;

  assign last_col = (DIM_P1_W'(col_r) + DIM_P1_W'(1)) >= DIM_P1_W'(cfg.eff_width);
  assign last_row = (DIM_P1_W'(row_r) + DIM_P1_W'(1)) >= DIM_P1_W'(cfg.eff_height);

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    luma_ptr_nxt   = luma_ptr_r;
    chroma_off_nxt = chroma_off_r;
    priority if (cfg.restart || (advance && last_col && last_row)) begin
      col_nxt        = '0;
      row_nxt        = '0;
      luma_ptr_nxt   = '0;
      chroma_off_nxt = '0;
    end else if (advance && last_col) begin
      // chroma row moves on after every odd luma row
      if (row_r[0]) begin
        chroma_off_nxt = chroma_off_r + CHROMA_ADDR_W'(cfg.eff_width);
      end
      row_nxt      = row_r + ROW_W'(1);
      col_nxt      = '0;
      luma_ptr_nxt = luma_ptr_r + LUMA_ADDR_W'(1);
    end else if (advance) begin
      col_nxt      = col_r + COL_W'(1);
      luma_ptr_nxt = luma_ptr_r + LUMA_ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      luma_ptr_r   <= '0;
      chroma_off_r <= '0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      luma_ptr_r   <= luma_ptr_nxt;
      chroma_off_r <= chroma_off_nxt;
    end
  end

  assign col_even           = col_r & ~COL_W'(1);
  assign pos.luma_address   = luma_ptr_r;
  assign pos.chroma_address = cfg.frame_size + chroma_off_r + CHROMA_ADDR_W'(col_even);
  assign pos.frame_end      = last_col && last_row;

endmodule

// File: hw/rtl/rgb_to_nv21_pixel_converter_top.sv
// top level of the rgb to nv21 pixel converter
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | request in| in_valid / in_stall  | in_pixel_word
//  out_    | request out| out_valid / out_stall| luma/chroma addresses, y, v, u, frame_end
//  apb     | config    | psel/penable/pready  | frame_width @0x0, frame_height @0x4
//
// one pixel request per clock sustained while out_stall is low; each passes two registers
// (input register, then colour maths and address adders into the result register)
// the input register refills while a finished result waits under out_stall, so in_stall
// only rises when both registers are full and the output is stalled
// rst_n is synchronous; it restores 640x480 and the frame start, no clearing pass
// a register write restarts the frame at the first pixel
module rgb_to_nv21_pixel_converter_top
  import rnv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input pixel channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_W-1:0]         in_pixel_word,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [LUMA_ADDR_W-1:0]   out_luma_address,
  output logic [BYTE_W-1:0]        out_luma_value,
  output logic [CHROMA_ADDR_W-1:0] out_chroma_address,
  output logic [BYTE_W-1:0]        out_v_value,
  output logic [BYTE_W-1:0]        out_u_value,
  output logic                     out_frame_end,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  cfg_stat_t cfg;
  yuv_t      yuv;
  pos_t      pos;

  // input register stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             in_take;
  // result register stage
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  yuv_t             yuv_r;
  pos_t             pos_r;

  assign pready = 1'b1;

  rnv_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // the held pixel moves to the result register whenever that register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel_word;
    end
  end

  rnv_color u_color (
    .pixel_word (s1_pixel_r),
    .yuv        (yuv)
  );

  // counters step on the same edge the pixel lands in the result register
  rnv_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      yuv_r <= yuv;
      pos_r <= pos;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_luma_address   = pos_r.luma_address;
  assign out_luma_value     = yuv_r.luma;
  assign out_chroma_address = pos_r.chroma_address;
  assign out_v_value        = yuv_r.v;
  assign out_u_value        = yuv_r.u;
  assign out_frame_end      = pos_r.frame_end;

endmodule

// File: hw/rtl/rnv_checker.sv
// port-level checks for the converter top level, bound in below
module rnv_checker
  import rnv_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [PIX_W-1:0]         in_pixel_word,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [LUMA_ADDR_W-1:0]   out_luma_address,
  input logic [BYTE_W-1:0]        out_luma_value,
  input logic [CHROMA_ADDR_W-1:0] out_chroma_address,
  input logic [BYTE_W-1:0]        out_v_value,
  input logic [BYTE_W-1:0]        out_u_value,
  input logic                     out_frame_end
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_luma_address)
      && $stable(out_chroma_address) && $stable(out_luma_value)
      && $stable(out_v_value) && $stable(out_u_value) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // input only backs up when the result side is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
      in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a stalled pixel request stays on offer unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_stall |=> in_valid && $stable(in_pixel_word))
    else $error("pixel request changed while stalled");

  a_luma_floor: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_luma_value >= 8'd16)
    else $error("luma below studio black");

  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind rgb_to_nv21_pixel_converter_top rnv_checker u_rnv_checker (.*);

// File: tb/tb_rgb_to_nv21_pixel_converter_top.sv
// self-checking testbench for the rgb to nv21 pixel converter top level
`timescale 1ns / 1ps

module tb_rgb_to_nv21_pixel_converter_top;
  import rnv_pkg::*;

  localparam int MAX_W      = 4096;
  localparam int MAX_H      = 4096;
  localparam int CYCLE_CAP  = 200000;  // far above the slowest legal run
  localparam int HOLD_LEN   = 60;      // long output hold-off, in cycles
  localparam int DRAIN_GAP  = 4;       // two-stage pipe plus margin
  localparam int RAND_PHASE = 8;
  localparam int PHASE_LEN  = 60;

  // one expected or observed result request
  typedef struct packed {
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic [BYTE_W-1:0]        luma_value;
    logic [CHROMA_ADDR_W-1:0] chroma_address;
    logic [BYTE_W-1:0]        v_value;
    logic [BYTE_W-1:0]        u_value;
    logic                     frame_end;
  } pixel_result_t;

  // converter predictor plus the queue of pixels still owed by the block
  class nv21_scoreboard;
    logic [CFG_DIM_W-1:0]     width_reg;
    logic [CFG_DIM_W-1:0]     height_reg;
    logic [11:0]              col_cnt;
    logic [11:0]              row_cnt;
    logic [LUMA_ADDR_W-1:0]   luma_ptr;
    logic [CHROMA_ADDR_W-1:0] chroma_base;
    pixel_result_t            owed_q[$];
    int                       errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors     = 0;
      restart_frame();
    endfunction

    function int clip_dim(logic [CFG_DIM_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
    endfunction

    function void restart_frame();
      col_cnt     = '0;
      row_cnt     = '0;
      luma_ptr    = '0;
      chroma_base = CHROMA_ADDR_W'(clip_dim(width_reg, MAX_W) * clip_dim(height_reg, MAX_H));
    endfunction

    function void write_reg(logic idx, logic [APB_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val[CFG_DIM_W-1:0];
      else                        height_reg = val[CFG_DIM_W-1:0];
      restart_frame();
    endfunction

    function logic [BYTE_W-1:0] sat_byte(int v, int lo);
      if (v < lo) return BYTE_W'(lo);
      if (v > 255) return 8'd255;
      return BYTE_W'(v);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] word);
      pixel_result_t want;
      int r, g, b, w, h, ysum, usum, vsum;
      bit last_col, last_row;
      r = int'(word[7:0]);
      g = int'(word[15:8]);
      b = int'(word[23:16]);
      w = clip_dim(width_reg, MAX_W);
      h = clip_dim(height_reg, MAX_H);
      // biased sums stay non-negative, so the shift floors
      ysum = 66 * r + 129 * g + 25 * b + 128;
      usum = -38 * r - 74 * g + 112 * b + 128 + 32768;
      vsum = 112 * r - 94 * g - 18 * b + 128 + 32768;
      last_col = (int'(col_cnt) + 1 >= w);
      last_row = (int'(row_cnt) + 1 >= h);
      want.luma_address   = luma_ptr;
      want.luma_value     = sat_byte((ysum >> 8) + 16, 16);
      want.chroma_address = chroma_base + CHROMA_ADDR_W'({col_cnt[11:1], 1'b0});
      want.v_value        = sat_byte(vsum >> 8, 0);
      want.u_value        = sat_byte(usum >> 8, 0);
      want.frame_end      = last_col && last_row;
      owed_q.push_back(want);
      if (last_col && last_row) begin
        restart_frame();
      end else if (last_col) begin
        if (row_cnt[0]) chroma_base = chroma_base + CHROMA_ADDR_W'(w);
        row_cnt  = row_cnt + 1'b1;
        col_cnt  = '0;
        luma_ptr = luma_ptr + 1'b1;
      end else begin
        col_cnt  = col_cnt + 1'b1;
        luma_ptr = luma_ptr + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual luma_address %0d",
                 $time, got.luma_address);
        return;
      end
      want = owed_q.pop_front();
      compare_field("luma_address", want.luma_address, got.luma_address);
      compare_field("luma_value", want.luma_value, got.luma_value);
      compare_field("chroma_address", want.chroma_address, got.chroma_address);
      compare_field("v_value", want.v_value, got.v_value);
      compare_field("u_value", want.u_value, got.u_value);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [PIX_W-1:0]         in_pixel_word;
  logic                     out_valid;
  logic                     out_stall;
  logic [LUMA_ADDR_W-1:0]   out_luma_address;
  logic [BYTE_W-1:0]        out_luma_value;
  logic [CHROMA_ADDR_W-1:0] out_chroma_address;
  logic [BYTE_W-1:0]        out_v_value;
  logic [BYTE_W-1:0]        out_u_value;
  logic                     out_frame_end;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  nv21_scoreboard sb;
  bit             calm;      // no idling on either side while set
  bit             hold_req;  // asks the receiver for one long hold-off
  int             cycle_cnt;

  // directed pixels: black, white, primaries, secondaries, alpha only, checker patterns
  logic [PIX_W-1:0] edge_px [0:11] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00,
    32'h00FF_0000, 32'hFF00_0000, 32'h00FF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h00FF_00FF, 32'h0000_FFFF, 32'h7F80_017F
  };

  rgb_to_nv21_pixel_converter_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_word      (in_pixel_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_luma_address   (out_luma_address),
    .out_luma_value     (out_luma_value),
    .out_chroma_address (out_chroma_address),
    .out_v_value        (out_v_value),
    .out_u_value        (out_u_value),
    .out_frame_end      (out_frame_end),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one pixel request, with random idle cycles in front, and hold it until taken
  task automatic send_pixel(input logic [PIX_W-1:0] word);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_word <= word;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(word);
    @(negedge clk);
  endtask

  // lower the request and wait until every owed result is out, plus pipe latency
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // apb write (setup then access), then a read back of the same register
  task automatic cfg_write_check(input logic idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== APB_DATA_W'(val[CFG_DIM_W-1:0])) begin
      sb.errors++;
      $display("%0t mismatch register %0d read: expected %0d actual %0d",
               $time, idx, val[CFG_DIM_W-1:0], got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random dimension: mostly tiny frames so frame ends come often, a few extremes
  function automatic logic [APB_DATA_W-1:0] pick_dim(input int small_max);
    logic [APB_DATA_W-1:0] junk;
    logic [CFG_DIM_W-1:0]  dim;
    junk = $urandom();
    case ($urandom_range(9))
      0:       dim = '0;
      1:       dim = CFG_DIM_W'($urandom_range(DIM_MAX_VAL, MAX_W));
      2:       dim = CFG_DIM_W'(MAX_W);
      default: dim = CFG_DIM_W'($urandom_range(small_max, 1));
    endcase
    // upper bus bits carry noise that the register must drop
    return {junk[APB_DATA_W-1:CFG_DIM_W], dim};
  endfunction

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 26);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_luma_address, out_luma_value, out_chroma_address,
                        out_v_value, out_u_value, out_frame_end});
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL rgb_to_nv21_pixel_converter_top");
    $finish;
  end

  initial begin
    sb            = new();
    calm          = 1'b0;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pixel_word = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size 640x480: colour extremes with the reset frame geometry
    for (int i = 0; i < 8; i++) send_pixel(edge_px[i]);
    drain_block();

    // zero width and height saturate to one, so every pixel ends a frame
    cfg_write_check(REG_FRAME_WIDTH, 32'hFFFF_E000);
    cfg_write_check(REG_FRAME_HEIGHT, 32'h0000_0000);
    for (int i = 8; i < 12; i++) send_pixel(edge_px[i]);
    drain_block();

    // all-ones registers saturate to the 4096 maximum
    cfg_write_check(REG_FRAME_WIDTH, DIM_MAX_VAL);
    cfg_write_check(REG_FRAME_HEIGHT, DIM_MAX_VAL);
    for (int i = 0; i < 4; i++) send_pixel(edge_px[i + 1]);
    drain_block();

    // one full-width row, then one-pixel-wide tall frame
    cfg_write_check(REG_FRAME_WIDTH, MAX_W);
    cfg_write_check(REG_FRAME_HEIGHT, 32'd1);
    for (int i = 0; i < 3; i++) send_pixel(edge_px[i + 5]);
    drain_block();
    cfg_write_check(REG_FRAME_WIDTH, 32'd1);
    cfg_write_check(REG_FRAME_HEIGHT, MAX_H);
    for (int i = 0; i < 3; i++) send_pixel(edge_px[i + 8]);
    drain_block();

    // random phases; one of them runs without idling, another takes the long hold-off
    for (int p = 0; p < RAND_PHASE; p++) begin
      if ($urandom_range(1)) begin
        cfg_write_check(REG_FRAME_WIDTH, pick_dim(9));
        cfg_write_check(REG_FRAME_HEIGHT, pick_dim(7));
      end else begin
        cfg_write_check(REG_FRAME_HEIGHT, pick_dim(7));
        cfg_write_check(REG_FRAME_WIDTH, pick_dim(9));
      end
      calm = (p == 3);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 1 && i == 10) hold_req = 1'b1;
        send_pixel($urandom());
      end
      drain_block();
      calm = 1'b0;
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("PASS rgb_to_nv21_pixel_converter_top");
    end else begin
      if (sb.owed_q.size() != 0)
        $display("%0t results missing: expected %0d more actual 0", $time, sb.owed_q.size());
      $display("FAIL rgb_to_nv21_pixel_converter_top");
    end
    $finish;
  end

endmodule
